>>> rtl/esc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants and types for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int DIV_W       = 64;
    localparam int PRE_STAGES  = 10;
    localparam int POST_STAGES = 5;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP_CALIB    = 3'd0,
        REG_PRESS_CALIB_A = 3'd1,
        REG_PRESS_CALIB_B = 3'd2,
        REG_PRESS_CALIB_C = 3'd3,
        REG_HUM_CALIB_A   = 3'd4,
        REG_HUM_CALIB_B   = 3'd5
    } reg_index_t;

    localparam logic signed [33:0] T_FINE_P_OFS = 34'sd128000;
    localparam logic [63:0]        P_BASE       = 64'd1048576;
    localparam logic [11:0]        P_SCALE      = 12'd3125;
    localparam logic [63:0]        P_VAR1_OFS   = 64'h0000_8000_0000_0000;
    localparam logic signed [31:0] T_FINE_H_OFS = 32'sd76800;
    localparam logic [31:0]        HUM_MAX_Q    = 32'd419430400;
    localparam logic signed [31:0] H_BIAS_A     = 32'sd2097152;
    localparam logic [31:0]        H_ROUND_L    = 32'd16384;
    localparam logic signed [31:0] H_BIAS_B     = 32'sd32768;
    localparam logic signed [31:0] H_ROUND_R    = 32'sd8192;

    // results that ride alongside the divider
    typedef struct packed {
        logic        neg;
        logic        invalid;
        logic [31:0] temperature;
        logic [16:0] humidity;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        side_t            side;
    } div_req_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] quo;
        side_t            side;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/esc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc channel interfaces
// Raw sample channel and compensated result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface esc_sample_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_press;
    logic [19:0] raw_temp;
    logic [15:0] raw_hum;

    modport source (output valid, raw_press, raw_temp, raw_hum, input ready);
    modport sink   (input valid, raw_press, raw_temp, raw_hum, output ready);
endinterface

interface esc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic               press_invalid;
    logic [16:0]        humidity;

    modport source (output valid, temperature, pressure, press_invalid, humidity,
                    input ready);
    modport sink   (input valid, temperature, pressure, press_invalid, humidity,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/esc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module esc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire esc_pkg::div_req_t req,
    output esc_pkg::div_rsp_t      rsp
);

    typedef struct packed {
        logic [esc_pkg::DIV_W-1:0] rem;
        logic [esc_pkg::DIV_W-1:0] acc;
        logic [esc_pkg::DIV_W-1:0] den;
        esc_pkg::side_t            side;
    } stage_t;

    stage_t                    stage_in   [0:esc_pkg::DIV_W-1];
    stage_t                    stage_next [0:esc_pkg::DIV_W-1];
    stage_t                    stage_reg  [0:esc_pkg::DIV_W-1];
    logic [esc_pkg::DIV_W-1:0] vld_reg;

    assign stage_in[0] = '{rem: '0, acc: req.num, den: req.den, side: req.side};

    for (genvar k = 1; k < esc_pkg::DIV_W; k++) begin : g_link
        assign stage_in[k] = stage_reg[k-1];
    end

    // acc shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb
    begin
        logic [esc_pkg::DIV_W:0] trial;
        for (int k = 0; k < esc_pkg::DIV_W; k++)
        begin
            trial = {stage_in[k].rem, stage_in[k].acc[esc_pkg::DIV_W-1]}
                    - {1'b0, stage_in[k].den};
            stage_next[k] = stage_in[k];
            if (!trial[esc_pkg::DIV_W])
            begin
                stage_next[k].rem = trial[esc_pkg::DIV_W-1:0];
                stage_next[k].acc = {stage_in[k].acc[esc_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                stage_next[k].rem = {stage_in[k].rem[esc_pkg::DIV_W-2:0],
                                     stage_in[k].acc[esc_pkg::DIV_W-1]};
                stage_next[k].acc = {stage_in[k].acc[esc_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[esc_pkg::DIV_W-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < esc_pkg::DIV_W; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign rsp = '{valid: vld_reg[esc_pkg::DIV_W-1],
                   quo:   stage_reg[esc_pkg::DIV_W-1].acc,
                   side:  stage_reg[esc_pkg::DIV_W-1].side};

endmodule
`default_nettype wire

>>> rtl/env_sensor_compensation.sv
`default_nettype none
// pipeline: sample beat to result beat passes 10 front stages,
//   64 divider stages and 5 back stages; the 64-bit pressure division is the longest part
// throughput: one sample beat per cycle while the result side takes beats
// reset: rst_n clears all valid bits and all calibration registers to zero;
//   datapath registers are not reset
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    esc_sample_if.sink                             sample,
    esc_result_if.source                           result,
    input  wire logic                              cfg_we,
    input  wire logic [esc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_calib_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [47:0] press_c_reg;
    logic [31:0] hum_a_reg;
    logic [31:0] hum_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
            hum_a_reg      <= '0;
            hum_b_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                esc_pkg::REG_TEMP_CALIB:    temp_calib_reg <= cfg_data;
                esc_pkg::REG_PRESS_CALIB_A: press_a_reg    <= cfg_data;
                esc_pkg::REG_PRESS_CALIB_B: press_b_reg    <= cfg_data;
                esc_pkg::REG_PRESS_CALIB_C: press_c_reg    <= cfg_data;
                esc_pkg::REG_HUM_CALIB_A:   hum_a_reg      <= cfg_data[31:0];
                esc_pkg::REG_HUM_CALIB_B:   hum_b_reg      <= cfg_data[31:0];
                default: ; // unused indexes are dropped
            endcase
        end
    end

    // calibration words, unpacked
    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]         h1, h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = temp_calib_reg[31:16];
    assign t3 = temp_calib_reg[47:32];
    assign p1 = press_a_reg[15:0];
    assign p2 = press_a_reg[31:16];
    assign p3 = press_a_reg[47:32];
    assign p4 = press_b_reg[15:0];
    assign p5 = press_b_reg[31:16];
    assign p6 = press_b_reg[47:32];
    assign p7 = press_c_reg[15:0];
    assign p8 = press_c_reg[31:16];
    assign p9 = press_c_reg[47:32];
    assign h1 = hum_a_reg[7:0];
    assign h2 = hum_a_reg[23:8];
    assign h3 = hum_a_reg[31:24];
    assign h4 = hum_b_reg[11:0];
    assign h5 = hum_b_reg[23:12];
    assign h6 = hum_b_reg[31:24];

    // ------------------------------------------------------------------
    // flow control: every stage advances when the output register is free
    // or its beat is being taken; bubbles travel as cleared valid bits
    // ------------------------------------------------------------------
    logic adv;
    logic [esc_pkg::PRE_STAGES-1:0]  pre_vld_reg;
    logic [esc_pkg::POST_STAGES-1:0] post_vld_reg;
    esc_pkg::div_req_t div_req;
    esc_pkg::div_rsp_t div_rsp;

    assign adv          = !result.valid || result.ready;
    assign sample.ready = adv;
    assign result.valid = post_vld_reg[esc_pkg::POST_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
        end
        else if (adv)
        begin
            pre_vld_reg  <= {pre_vld_reg[esc_pkg::PRE_STAGES-2:0], sample.valid};
            post_vld_reg <= {post_vld_reg[esc_pkg::POST_STAGES-2:0], div_rsp.valid};
        end
    end

    // raw readings and temperature carried to where they are consumed
    logic [19:0] rp_reg   [1:6];
    logic [15:0] rh_reg   [1:4];
    logic [31:0] temp_reg [4:9];

    // ------------------------------------------------------------------
    // stage 1: temperature products
    // ------------------------------------------------------------------
    logic signed [17:0] s1_tdiff;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_ta, s1_dd;
    logic [31:0]        s1_ta_reg, s1_dd_reg;

    assign s1_tdiff = {1'b0, sample.raw_temp[19:3]} - {1'b0, t1, 1'b0};
    assign s1_d     = {1'b0, sample.raw_temp[19:4]} - {1'b0, t1};
    assign s1_ta    = s1_tdiff * t2;
    assign s1_dd    = s1_d * s1_d;

    // ------------------------------------------------------------------
    // stage 2: second temperature term
    // ------------------------------------------------------------------
    logic signed [31:0] s2_ta;
    logic signed [19:0] s2_ddsh;
    logic signed [35:0] s2_b;
    logic signed [31:0] s2_a_reg, s2_b_reg;

    assign s2_ta   = s1_ta_reg;
    assign s2_ddsh = s1_dd_reg[31:12];
    assign s2_b    = s2_ddsh * t3;

    // ------------------------------------------------------------------
    // stage 3: fine temperature
    // ------------------------------------------------------------------
    logic signed [31:0] s3_bsh;
    logic signed [31:0] s3_tfine_reg;

    assign s3_bsh = s2_b_reg >>> 14;

    // ------------------------------------------------------------------
    // stage 4: temperature result, first pressure and humidity products
    // ------------------------------------------------------------------
    logic signed [31:0] s4_t5, s4_temp;
    logic signed [33:0] s4_v1;
    logic signed [67:0] s4_v1sq;
    logic signed [49:0] s4_v1p5, s4_v1p2;
    logic signed [31:0] s4_x;
    logic signed [43:0] s4_h5x;
    logic signed [39:0] s4_xh6;
    logic signed [40:0] s4_xh3;
    logic signed [63:0] s4_v1sq_reg;
    logic signed [49:0] s4_v1p5_reg, s4_v1p2_reg;
    logic [31:0]        s4_h5x_reg;
    logic signed [31:0] s4_xh6_reg, s4_xh3_reg;

    assign s4_t5   = s3_tfine_reg * 32'sd5 + 32'sd128;
    assign s4_temp = s4_t5 >>> 8;
    assign s4_v1   = s3_tfine_reg - esc_pkg::T_FINE_P_OFS;
    assign s4_v1sq = s4_v1 * s4_v1;
    assign s4_v1p5 = s4_v1 * p5;
    assign s4_v1p2 = s4_v1 * p2;
    assign s4_x    = s3_tfine_reg - esc_pkg::T_FINE_H_OFS;
    assign s4_h5x  = s4_x * h5;
    assign s4_xh6  = s4_x * h6;
    assign s4_xh3  = s4_x * $signed({1'b0, h3});

    // ------------------------------------------------------------------
    // stage 5: calibration scaling of var2 / var1, humidity left term
    // ------------------------------------------------------------------
    logic signed [79:0] s5_v2a, s5_v1a;
    logic signed [31:0] s5_lsum, s5_left;
    logic signed [31:0] s5_xh6sh, s5_xh3sh, s5_b, s5_inner;
    logic signed [63:0] s5_v2a_reg, s5_v1a_reg;
    logic signed [49:0] s5_v1p5_reg, s5_v1p2_reg;
    logic signed [31:0] s5_left_reg, s5_inner_reg;

    assign s5_v2a   = s4_v1sq_reg * p6;
    assign s5_v1a   = s4_v1sq_reg * p3;
    assign s5_lsum  = {2'b0, rh_reg[4], 14'b0} - {h4, 20'b0} - s4_h5x_reg
                      + esc_pkg::H_ROUND_L;
    assign s5_left  = s5_lsum >>> 15;
    assign s5_xh6sh = s4_xh6_reg >>> 10;
    assign s5_xh3sh = s4_xh3_reg >>> 11;
    assign s5_b     = s5_xh3sh + esc_pkg::H_BIAS_B;
    assign s5_inner = s5_xh6sh * s5_b;

    // ------------------------------------------------------------------
    // stage 6: var2 / var1 sums, humidity right product
    // ------------------------------------------------------------------
    logic signed [63:0] s6_v1p5x, s6_v1p2x, s6_p4x, s6_v1ash;
    logic signed [63:0] s6_v2, s6_v1b;
    logic signed [31:0] s6_innsh, s6_c, s6_h2x, s6_rprod;
    logic signed [63:0] s6_v2_reg, s6_v1b_reg;
    logic signed [31:0] s6_left_reg, s6_rprod_reg;

    assign s6_v1p5x = 64'(s5_v1p5_reg);
    assign s6_v1p2x = 64'(s5_v1p2_reg);
    assign s6_p4x   = 64'(p4);
    assign s6_v1ash = s5_v1a_reg >>> 8;
    assign s6_v2    = s5_v2a_reg + (s6_v1p5x <<< 17) + (s6_p4x <<< 35);
    assign s6_v1b   = s6_v1ash + (s6_v1p2x <<< 12);
    assign s6_innsh = s5_inner_reg >>> 10;
    assign s6_c     = s6_innsh + esc_pkg::H_BIAS_A;
    assign s6_h2x   = 32'(h2);
    assign s6_rprod = s6_c * s6_h2x + esc_pkg::H_ROUND_R;

    // ------------------------------------------------------------------
    // stage 7: divisor product, dividend base, humidity product
    // ------------------------------------------------------------------
    logic [63:0]        s7_base, s7_pd, s7_numpre;
    logic [79:0]        s7_var1p;
    logic signed [31:0] s7_right, s7_hv;
    logic signed [63:0] s7_var1p_reg;
    logic [63:0]        s7_numpre_reg;
    logic signed [31:0] s7_hv_reg;

    assign s7_base   = esc_pkg::P_VAR1_OFS + s6_v1b_reg;
    assign s7_var1p  = s7_base * p1;
    assign s7_pd     = esc_pkg::P_BASE - {44'b0, rp_reg[6]};
    assign s7_numpre = (s7_pd << 31) - s6_v2_reg;
    assign s7_right  = s6_rprod_reg >>> 14;
    assign s7_hv     = s6_left_reg * s7_right;

    // ------------------------------------------------------------------
    // stage 8: divisor, scaled dividend, humidity square
    // ------------------------------------------------------------------
    logic signed [63:0] s8_var1;
    logic [75:0]        s8_num;
    logic signed [31:0] s8_s15, s8_sq;
    logic signed [63:0] s8_var1_reg;
    logic [63:0]        s8_num_reg;
    logic signed [31:0] s8_hv_reg, s8_sq_reg;

    assign s8_var1 = s7_var1p_reg >>> 33;
    assign s8_num  = s7_numpre_reg * esc_pkg::P_SCALE;
    assign s8_s15  = s7_hv_reg >>> 15;
    assign s8_sq   = s8_s15 * s8_s15;

    // ------------------------------------------------------------------
    // stage 9: humidity correction product
    // ------------------------------------------------------------------
    logic signed [31:0] s9_sqsh;
    logic signed [40:0] s9_t;
    logic signed [31:0] s9_t_reg, s9_hv_reg;
    logic [63:0]        s9_var1_reg, s9_num_reg;

    assign s9_sqsh = s8_sq_reg >>> 7;
    assign s9_t    = s9_sqsh * $signed({1'b0, h1});

    // ------------------------------------------------------------------
    // stage 10: humidity clamp, operand magnitudes for the divider
    // ------------------------------------------------------------------
    logic signed [31:0] s10_tsh, s10_hv;
    logic [16:0]        s10_hum;
    logic [63:0]        s10_un, s10_ud;
    logic [63:0]        s10_num_reg, s10_den_reg;
    esc_pkg::side_t     s10_side_reg;

    assign s10_tsh = s9_t_reg >>> 4;
    assign s10_hv  = s9_hv_reg - s10_tsh;

    always_comb
    begin
        if (s10_hv[31])
        begin
            s10_hum = '0;
        end
        else if (s10_hv[30:0] > esc_pkg::HUM_MAX_Q[30:0])
        begin
            s10_hum = esc_pkg::HUM_MAX_Q[28:12];
        end
        else
        begin
            s10_hum = s10_hv[28:12];
        end
    end

    assign s10_un = s9_num_reg[63]  ? (64'd0 - s9_num_reg)  : s9_num_reg;
    assign s10_ud = s9_var1_reg[63] ? (64'd0 - s9_var1_reg) : s9_var1_reg;

    // ------------------------------------------------------------------
    // front pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg[1] <= sample.raw_press;
            for (int k = 2; k <= 6; k++)
            begin
                rp_reg[k] <= rp_reg[k-1];
            end
            rh_reg[1] <= sample.raw_hum;
            for (int k = 2; k <= 4; k++)
            begin
                rh_reg[k] <= rh_reg[k-1];
            end
            temp_reg[4] <= s4_temp;
            for (int k = 5; k <= 9; k++)
            begin
                temp_reg[k] <= temp_reg[k-1];
            end

            s1_ta_reg    <= s1_ta[31:0];
            s1_dd_reg    <= s1_dd[31:0];

            s2_a_reg     <= s2_ta >>> 11;
            s2_b_reg     <= s2_b[31:0];

            s3_tfine_reg <= s2_a_reg + s3_bsh;

            s4_v1sq_reg  <= s4_v1sq[63:0];
            s4_v1p5_reg  <= s4_v1p5;
            s4_v1p2_reg  <= s4_v1p2;
            s4_h5x_reg   <= s4_h5x[31:0];
            s4_xh6_reg   <= s4_xh6[31:0];
            s4_xh3_reg   <= s4_xh3[31:0];

            s5_v2a_reg   <= s5_v2a[63:0];
            s5_v1a_reg   <= s5_v1a[63:0];
            s5_v1p5_reg  <= s4_v1p5_reg;
            s5_v1p2_reg  <= s4_v1p2_reg;
            s5_left_reg  <= s5_left;
            s5_inner_reg <= s5_inner;

            s6_v2_reg    <= s6_v2;
            s6_v1b_reg   <= s6_v1b;
            s6_left_reg  <= s5_left_reg;
            s6_rprod_reg <= s6_rprod;

            s7_var1p_reg  <= s7_var1p[63:0];
            s7_numpre_reg <= s7_numpre;
            s7_hv_reg     <= s7_hv;

            s8_var1_reg  <= s8_var1;
            s8_num_reg   <= s8_num[63:0];
            s8_hv_reg    <= s7_hv_reg;
            s8_sq_reg    <= s8_sq;

            s9_t_reg     <= s9_t[31:0];
            s9_hv_reg    <= s8_hv_reg;
            s9_var1_reg  <= s8_var1_reg;
            s9_num_reg   <= s8_num_reg;

            s10_num_reg  <= s10_un;
            s10_den_reg  <= s10_ud;
            s10_side_reg <= '{neg:         s9_num_reg[63] ^ s9_var1_reg[63],
                              invalid:     (s9_var1_reg == '0),
                              temperature: temp_reg[9],
                              humidity:    s10_hum};
        end
    end

    // ------------------------------------------------------------------
    // pressure division: magnitudes in, one quotient bit per stage
    // ------------------------------------------------------------------
    assign div_req = '{valid: pre_vld_reg[esc_pkg::PRE_STAGES-1],
                       num:   s10_num_reg,
                       den:   s10_den_reg,
                       side:  s10_side_reg};

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // back stages: sign fix, var1 = p9 * h13^2, var2 = p8 * p, final sum
    // ------------------------------------------------------------------
    esc_pkg::side_t     side_reg [1:4];
    logic signed [63:0] q1_pres_reg;

    logic signed [63:0] q2_h13;
    logic [31:0]        q2_lo, q2_hi, q2_lh;
    logic [63:0]        q2_ll;
    logic signed [79:0] q2_p8;
    logic [63:0]        q2_ll_reg;
    logic [31:0]        q2_lh_reg;
    logic signed [63:0] q2_p8_reg, q2_pres_reg;

    logic signed [63:0] q3_hsq, q3_v2;
    logic signed [63:0] q3_hsq_reg, q3_v2_reg, q3_pres_reg;

    logic signed [79:0] q4_p9;
    logic signed [63:0] q4_p9_reg, q4_v2_reg, q4_pres_reg;

    logic signed [63:0] q5_v1, q5_sum;
    logic signed [31:0] q5_p7x;
    logic [31:0]        q5_pr;

    logic [31:0]        out_temp_reg;
    logic [31:0]        out_press_reg;
    logic               out_inv_reg;
    logic [16:0]        out_hum_reg;

    assign q2_h13 = q1_pres_reg >>> 13;
    assign q2_lo  = q2_h13[31:0];
    assign q2_hi  = q2_h13[63:32];
    // low 64 bits of h13 squared from 32-bit halves
    assign q2_ll  = q2_lo * q2_lo;
    assign q2_lh  = q2_lo * q2_hi;
    assign q2_p8  = q1_pres_reg * p8;

    assign q3_hsq = q2_ll_reg + {q2_lh_reg[30:0], 33'b0};
    assign q3_v2  = q2_p8_reg >>> 19;

    assign q4_p9  = q3_hsq_reg * p9;

    assign q5_v1  = q4_p9_reg >>> 25;
    assign q5_sum = q4_pres_reg + q5_v1 + q4_v2_reg;
    assign q5_p7x = 32'(p7);
    assign q5_pr  = q5_sum[39:8] + (q5_p7x <<< 4);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1]  <= div_rsp.side;
            q1_pres_reg  <= div_rsp.side.neg ? (64'd0 - div_rsp.quo) : div_rsp.quo;

            side_reg[2]  <= side_reg[1];
            q2_ll_reg    <= q2_ll;
            q2_lh_reg    <= q2_lh;
            q2_p8_reg    <= q2_p8[63:0];
            q2_pres_reg  <= q1_pres_reg;

            side_reg[3]  <= side_reg[2];
            q3_hsq_reg   <= q3_hsq;
            q3_v2_reg    <= q3_v2;
            q3_pres_reg  <= q2_pres_reg;

            side_reg[4]  <= side_reg[3];
            q4_p9_reg    <= q4_p9[63:0];
            q4_v2_reg    <= q3_v2_reg;
            q4_pres_reg  <= q3_pres_reg;

            // output register
            out_temp_reg  <= side_reg[4].temperature;
            out_press_reg <= side_reg[4].invalid ? '1 : q5_pr;
            out_inv_reg   <= side_reg[4].invalid;
            out_hum_reg   <= side_reg[4].humidity;
        end
    end

    assign result.temperature   = out_temp_reg;
    assign result.pressure      = out_press_reg;
    assign result.press_invalid = out_inv_reg;
    assign result.humidity      = out_hum_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_invalid_ones: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.press_invalid |-> result.pressure == '1)
        else $error("invalid pressure beat without all-ones value");

    a_hum_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.humidity <= esc_pkg::HUM_MAX_Q[28:12])
        else $error("humidity beyond full scale");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pre_vld_reg) && $stable(post_vld_reg))
        else $error("valid bits moved during a stall");

endmodule
`default_nettype wire

>>> test/esc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esc_checker
// Watches the sample and result channels, computes the compensated triple
// for every accepted sample and compares each result beat in order.
// ----------------------------------------------------------------------------
module esc_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    esc_sample_if.sink  sample,
    esc_result_if.sink  result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] pressure;
        logic        press_invalid;
        logic [16:0] humidity;
    } comp_t;

    logic [47:0] t_cal, pa_cal, pb_cal, pc_cal;
    logic [31:0] ha_cal, hb_cal;
    comp_t       comp_q[$];

    function automatic logic signed [63:0] sdiv(logic signed [63:0] n, logic signed [63:0] d);
        logic [63:0] un, ud, q;
        un = n[63] ? -n : n;
        ud = d[63] ? -d : d;
        q  = un / ud;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic comp_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
        comp_t r;
        logic signed [31:0] t1, t2, t3, a, d, b, tfine, x, lft, inner, rgt, hv, s15;
        logic signed [31:0] h1, h2, h3, h4, h5, h6;
        logic signed [63:0] v1, v2, p, h13, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t1 = {16'd0, t_cal[15:0]};
        t2 = {{16{t_cal[31]}}, t_cal[31:16]};
        t3 = {{16{t_cal[47]}}, t_cal[47:32]};
        a = (({12'd0, rt} >>> 3) - (t1 <<< 1)) * t2;
        a = a >>> 11;
        d = ({12'd0, rt} >>> 4) - t1;
        b = d * d;
        b = (b >>> 12) * t3;
        b = b >>> 14;
        tfine = a + b;
        r.temperature = (tfine * 5 + 128) >>> 8;

        p1 = {48'd0, pa_cal[15:0]};
        p2 = {{48{pa_cal[31]}}, pa_cal[31:16]};
        p3 = {{48{pa_cal[47]}}, pa_cal[47:32]};
        p4 = {{48{pb_cal[15]}}, pb_cal[15:0]};
        p5 = {{48{pb_cal[31]}}, pb_cal[31:16]};
        p6 = {{48{pb_cal[47]}}, pb_cal[47:32]};
        p7 = {{48{pc_cal[15]}}, pc_cal[15:0]};
        p8 = {{48{pc_cal[31]}}, pc_cal[31:16]};
        p9 = {{48{pc_cal[47]}}, pc_cal[47:32]};
        v1 = 64'(tfine) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0)
        begin
            r.pressure = 32'hFFFF_FFFF;
            r.press_invalid = 1'b1;
        end
        else
        begin
            p = 64'sd1048576 - 64'(rp);
            p = sdiv(((p <<< 31) - v2) * 64'sd3125, v1);
            h13 = p >>> 13;
            v1 = (p9 * h13 * h13) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.pressure = p[31:0];
            r.press_invalid = 1'b0;
        end

        h1 = {24'd0, ha_cal[7:0]};
        h2 = {{16{ha_cal[23]}}, ha_cal[23:8]};
        h3 = {24'd0, ha_cal[31:24]};
        h4 = {{20{hb_cal[11]}}, hb_cal[11:0]};
        h5 = {{20{hb_cal[23]}}, hb_cal[23:12]};
        h6 = {{24{hb_cal[31]}}, hb_cal[31:24]};
        x = tfine - 32'sd76800;
        lft = ({16'd0, rh} <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384;
        lft = lft >>> 15;
        inner = x * h6;
        s15 = x * h3;
        inner = (inner >>> 10) * ((s15 >>> 11) + 32'sd32768);
        rgt = ((inner >>> 10) + 32'sd2097152) * h2 + 32'sd8192;
        rgt = rgt >>> 14;
        hv = lft * rgt;
        s15 = hv >>> 15;
        s15 = s15 * s15;
        s15 = (s15 >>> 7) * h1;
        hv = hv - (s15 >>> 4);
        if (hv[31])
            hv = 0;
        if (hv > 32'sd419430400)
            hv = 32'sd419430400;
        r.humidity = hv[28:12];
        return r;
    endfunction

    assign pending = comp_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_cal <= '0; pa_cal <= '0; pb_cal <= '0; pc_cal <= '0;
            ha_cal <= '0; hb_cal <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esc_pkg::REG_TEMP_CALIB:    t_cal  <= cfg_data;
                esc_pkg::REG_PRESS_CALIB_A: pa_cal <= cfg_data;
                esc_pkg::REG_PRESS_CALIB_B: pb_cal <= cfg_data;
                esc_pkg::REG_PRESS_CALIB_C: pc_cal <= cfg_data;
                esc_pkg::REG_HUM_CALIB_A:   ha_cal <= cfg_data[31:0];
                esc_pkg::REG_HUM_CALIB_B:   hb_cal <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    initial fail_count = 0;

    always @(posedge clk)
    begin
        comp_t e;
        if (rst_n && sample.valid && sample.ready)
            comp_q.push_back(compensate(sample.raw_press, sample.raw_temp, sample.raw_hum));
        if (rst_n && result.valid && result.ready)
        begin
            if (comp_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                e = comp_q.pop_front();
                if (result.temperature !== e.temperature)
                begin
                    $error("temperature exp %h got %h", e.temperature, result.temperature);
                    fail_count++;
                end
                if (result.pressure !== e.pressure)
                begin
                    $error("pressure exp %h got %h", e.pressure, result.pressure);
                    fail_count++;
                end
                if (result.press_invalid !== e.press_invalid)
                begin
                    $error("press_invalid exp %b got %b", e.press_invalid,
                           result.press_invalid);
                    fail_count++;
                end
                if (result.humidity !== e.humidity)
                begin
                    $error("humidity exp %h got %h", e.humidity, result.humidity);
                    fail_count++;
                end
            end
        end
    end
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw sensor samples and calibration sets into the compensation
// block with random gaps and result-side stalls; the checker does the rest.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY   = 79;
    localparam int MAX_CYCLE = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;

    esc_sample_if sample ();
    esc_result_if result ();

    env_sensor_compensation dut (
        .clk(clk), .rst_n(rst_n), .sample(sample), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    esc_checker chk (
        .clk(clk), .rst_n(rst_n), .sample(sample), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on total run length
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLE)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side: random stalls before each beat
    initial
    begin
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            repeat (gap)
            begin
                @(negedge clk);
                result.ready <= 1'b0;
            end
            @(negedge clk);
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
        end
    end

    task automatic write_reg(input esc_pkg::reg_index_t idx, input logic [47:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait for every expected beat, then let the pipe drain
    task automatic drain_pipe();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // one sample beat after a random gap; burst mode forces no gap
    task automatic send_sample(input logic [19:0] rp, input logic [19:0] rt,
                               input logic [15:0] rh, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap != 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        sample.valid     <= 1'b1;
        sample.raw_press <= rp;
        sample.raw_temp  <= rt;
        sample.raw_hum   <= rh;
        do @(posedge clk); while (!sample.ready);
    endtask

    task automatic end_samples();
        @(negedge clk);
        sample.valid <= 1'b0;
    endtask

    // calibration close to a real part, with random spread
    task automatic typical_calib();
        write_reg(esc_pkg::REG_TEMP_CALIB,
                  {16'($urandom_range(0, 100)), 16'(26000 + $urandom_range(0, 2000)),
                   16'(27000 + $urandom_range(0, 2000))});
        write_reg(esc_pkg::REG_PRESS_CALIB_A, {16'hD0B0 + 16'($urandom_range(0, 200)),
                                               16'hD600 + 16'($urandom_range(0, 200)),
                                               16'(36000 + $urandom_range(0, 2000))});
        write_reg(esc_pkg::REG_PRESS_CALIB_B, {16'hFFF9, 16'($urandom_range(0, 300)),
                                               16'(7000 + $urandom_range(0, 2000))});
        write_reg(esc_pkg::REG_PRESS_CALIB_C, {16'(4000 + $urandom_range(0, 1000)),
                                               16'hC000 + 16'($urandom_range(0, 500)),
                                               16'($urandom_range(0, 20))});
        write_reg(esc_pkg::REG_HUM_CALIB_A, {16'd0, 8'($urandom_range(0, 40)),
                                             16'(300 + $urandom_range(0, 200)),
                                             8'($urandom_range(60, 90))});
        write_reg(esc_pkg::REG_HUM_CALIB_B, {16'd0, 8'($urandom_range(20, 40)),
                                             12'($urandom_range(0, 100)),
                                             12'(300 + $urandom_range(0, 100))});
    endtask

    task automatic random_calib();
        write_reg(esc_pkg::REG_TEMP_CALIB,    48'({$urandom, $urandom}));
        write_reg(esc_pkg::REG_PRESS_CALIB_A, 48'({$urandom, $urandom}));
        write_reg(esc_pkg::REG_PRESS_CALIB_B, 48'({$urandom, $urandom}));
        write_reg(esc_pkg::REG_PRESS_CALIB_C, 48'({$urandom, $urandom}));
        write_reg(esc_pkg::REG_HUM_CALIB_A,   {16'd0, $urandom});
        write_reg(esc_pkg::REG_HUM_CALIB_B,   {16'd0, $urandom});
    endtask

    task automatic edge_calib(input bit ones);
        logic [47:0] v;
        v = ones ? '1 : '0;
        write_reg(esc_pkg::REG_TEMP_CALIB, v);
        write_reg(esc_pkg::REG_PRESS_CALIB_A, v);
        write_reg(esc_pkg::REG_PRESS_CALIB_B, v);
        write_reg(esc_pkg::REG_PRESS_CALIB_C, v);
        write_reg(esc_pkg::REG_HUM_CALIB_A, v);
        write_reg(esc_pkg::REG_HUM_CALIB_B, v);
    endtask

    initial
    begin
        int phase;
        bit burst;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        sample.valid     = 1'b0;
        sample.raw_press = '0;
        sample.raw_temp  = '0;
        sample.raw_hum   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset calibration gives a zero divisor
        send_sample(20'd0, 20'd0, 16'd0, 1'b0);
        send_sample('1, '1, '1, 1'b0);
        end_samples();
        drain_pipe();

        typical_calib();
        send_sample(20'd415148, 20'd519888, 16'd30000, 1'b0);
        send_sample(20'd0, 20'd0, 16'd0, 1'b0);
        send_sample('1, '1, '1, 1'b0);
        send_sample('1, 20'd0, 16'd0, 1'b0);
        send_sample(20'd0, '1, '1, 1'b0);
        send_sample(20'd300000, 20'd500000, 16'hFFFF, 1'b0);
        end_samples();
        drain_pipe();

        // all ones everywhere: wraps, clamps, sign extremes
        edge_calib(1'b1);
        send_sample(20'd0, 20'd0, 16'd0, 1'b0);
        send_sample('1, '1, '1, 1'b0);
        send_sample(20'h80000, 20'h80000, 16'h8000, 1'b0);
        end_samples();
        drain_pipe();

        // P1 = 1 and P2 minimum: small divisor; humidity calibration A is also set
        edge_calib(1'b0);
        write_reg(esc_pkg::REG_PRESS_CALIB_A, 48'h0000_8000_0001);
        write_reg(esc_pkg::REG_HUM_CALIB_A, 48'h00_7FFF_FF);
        send_sample(20'd0, '1, '1, 1'b0);
        send_sample('1, 20'd0, 16'd0, 1'b0);
        end_samples();
        drain_pipe();

        // random phases: mostly realistic calibration, some fully random
        for (phase = 0; phase < 22; phase++)
        begin
            if (phase % 4 == 3)
                random_calib();
            else
                typical_calib();
            for (int i = 0; i < 50; i++)
            begin
                burst = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 3) == 0)
                    send_sample(20'($urandom), 20'($urandom), 16'($urandom), burst);
                else
                    send_sample(20'($urandom_range(200000, 600000)),
                                20'($urandom_range(300000, 700000)),
                                16'($urandom_range(10000, 50000)), burst);
            end
            end_samples();
            drain_pipe();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
